// ===== rtl/tsb_pkg.sv =====
// Package for the transactional store buffer: payload structs, command and
// status codes, default geometry. No dependencies.
package tsb_pkg;

   localparam int ADDR_W           = 12;
   localparam int LINE_BYTES_DEF   = 64;
   localparam int BUFFER_LINES_DEF = 16;
   localparam logic [7:0] NEST_MAX = 8'd255;

   typedef enum logic [2:0] {
      CMD_LOAD  = 3'd0,
      CMD_STORE = 3'd1,
      CMD_BEGIN = 3'd2,
      CMD_END   = 3'd3,
      CMD_ABORT = 3'd4
   } cmd_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NO_TXN   = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [ADDR_W-1:0] addr;
      logic [1:0]        size_code;
      logic              sign_extend;
      logic [63:0]       store_data;
      logic [63:0]       abort_target;
      logic [7:0]        abort_code;
   } req_type;

   typedef struct packed {
      logic [63:0] load_data;
      logic [1:0]  status;
      logic        in_txn;
      logic        redirect_valid;
      logic [63:0] redirect_target;
      logic [7:0]  abort_reason;
   } rsp_type;

   typedef struct packed {
      logic alloc;
      logic clear;
   } dir_ctl_type;

endpackage

// ===== rtl/tsb_line_dir.sv =====
// Line directory of the store buffer: tags, valid bits, fill count, lookups.
// Depends on tsb_pkg.
module tsb_line_dir #(
   parameter int LINE_BYTES   = tsb_pkg::LINE_BYTES_DEF,
   parameter int BUFFER_LINES = tsb_pkg::BUFFER_LINES_DEF,
   parameter int TAG_W        = tsb_pkg::ADDR_W - $clog2(LINE_BYTES),
   parameter int SLOT_W       = (BUFFER_LINES > 1) ? $clog2(BUFFER_LINES) : 1,
   parameter int USED_W       = $clog2(BUFFER_LINES + 3)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tsb_pkg::dir_ctl_type  ctl,
   input  logic [SLOT_W-1:0]     wr_slot,
   input  logic [TAG_W-1:0]      wr_tag,
   input  logic [TAG_W-1:0]      tag_a,
   output logic                  hit_a,
   output logic [SLOT_W-1:0]     slot_a,
   input  logic [TAG_W-1:0]      tag_b,
   output logic                  hit_b,
   output logic [SLOT_W-1:0]     free_slot,
   output logic [USED_W-1:0]     used,
   input  logic [SLOT_W-1:0]     rd_idx,
   output logic                  rd_valid,
   output logic [TAG_W-1:0]      rd_tag
);
   import tsb_pkg::*;

   logic [TAG_W-1:0]        tag_ff [BUFFER_LINES];
   logic [BUFFER_LINES-1:0] valid_ff;
   logic [BUFFER_LINES-1:0] valid_in;
   logic [USED_W-1:0]       used_ff;
   logic [USED_W-1:0]       used_in;

   always_comb begin
      hit_a     = 1'b0;
      slot_a    = '0;
      hit_b     = 1'b0;
      free_slot = '0;
      for (int i = 0; i < BUFFER_LINES; i++) begin
         if (valid_ff[i] && tag_ff[i] == tag_a) begin
            hit_a  = 1'b1;
            slot_a = SLOT_W'(i);
         end
         if (valid_ff[i] && tag_ff[i] == tag_b) begin
            hit_b = 1'b1;
         end
      end
      for (int j = BUFFER_LINES - 1; j >= 0; j--) begin
         if (!valid_ff[j]) begin
            free_slot = SLOT_W'(j);
         end
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_tag   = tag_ff[rd_idx];
   assign used     = used_ff;

   always_comb begin
      valid_in = valid_ff;
      used_in  = used_ff;
      if (ctl.clear) begin
         valid_in = '0;
         used_in  = '0;
      end else if (ctl.alloc) begin
         valid_in[wr_slot] = 1'b1;
         used_in           = used_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.alloc) begin
         tag_ff[wr_slot] <= wr_tag;
      end
   end

   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      ctl.alloc |-> !valid_ff[wr_slot])
      else $error("line allocated into a slot that is in use");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(BUFFER_LINES))
      else $error("line count above buffer size");
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> used_ff == '0)
      else $error("line count not zero after clear");
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      ctl.alloc && !ctl.clear |=> used_ff == $past(used_ff) + 1'b1)
      else $error("line count did not follow allocation");

endmodule

// ===== rtl/tsb_mem.sv =====
// Backing memory with its zeroing sweep after reset, and the line data memory.
// Depends on tsb_pkg.
module tsb_mem #(
   parameter int LINE_BYTES   = tsb_pkg::LINE_BYTES_DEF,
   parameter int BUFFER_LINES = tsb_pkg::BUFFER_LINES_DEF,
   parameter int LB_AW        = ((BUFFER_LINES > 1) ? $clog2(BUFFER_LINES) : 1)
                                + $clog2(LINE_BYTES)
) (
   input  logic                      clock,
   input  logic                      reset,
   output logic                      clr_busy,
   input  logic                      bm_we,
   input  logic [tsb_pkg::ADDR_W-1:0] bm_addr,
   input  logic [7:0]                bm_wdata,
   output logic [7:0]                bm_rdata,
   input  logic                      lb_we,
   input  logic [LB_AW-1:0]          lb_addr,
   input  logic [7:0]                lb_wdata,
   output logic [7:0]                lb_rdata
);
   import tsb_pkg::*;

   localparam int MEM_SIZE = 1 << ADDR_W;
   localparam int LB_SIZE  = BUFFER_LINES * LINE_BYTES;

   logic [7:0]        bmem [MEM_SIZE];
   logic [7:0]        lmem [LB_SIZE];
   logic [7:0]        bm_rdata_ff;
   logic [7:0]        lb_rdata_ff;
   logic              clr_busy_ff;
   logic              clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == {ADDR_W{1'b1}}) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         bmem[clr_addr_ff] <= 8'd0;
      end else if (bm_we) begin
         bmem[bm_addr] <= bm_wdata;
      end
      bm_rdata_ff <= bmem[bm_addr];
   end

   always_ff @(posedge clock) begin
      if (lb_we) begin
         lmem[lb_addr] <= lb_wdata;
      end
      lb_rdata_ff <= lmem[lb_addr];
   end

   assign clr_busy = clr_busy_ff;
   assign bm_rdata = bm_rdata_ff;
   assign lb_rdata = lb_rdata_ff;

endmodule

// ===== rtl/transactional_store_buffer_unit.sv =====
// Transactional store buffer top level: request sequencer, line directory
// and memories. Depends on tsb_pkg, tsb_line_dir and tsb_mem.
// Loads and stores go byte by byte; a store in a transaction first fills any missing
// line from backing memory, and the outermost end copies every valid line back.
// One request at a time. After reset the backing memory is zeroed; no request is
// taken until that sweep is done.
module transactional_store_buffer_unit #(
   parameter int LINE_BYTES   = tsb_pkg::LINE_BYTES_DEF,
   parameter int BUFFER_LINES = tsb_pkg::BUFFER_LINES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tsb_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tsb_pkg::rsp_type rsp_payload
);
   import tsb_pkg::*;

   localparam int OFF_W  = $clog2(LINE_BYTES);
   localparam int TAG_W  = ADDR_W - OFF_W;
   localparam int SLOT_W = (BUFFER_LINES > 1) ? $clog2(BUFFER_LINES) : 1;
   localparam int USED_W = $clog2(BUFFER_LINES + 3);
   localparam int LB_AW  = SLOT_W + OFF_W;
   localparam int CNT_W  = OFF_W + 1;

   typedef enum logic [10:0] {
      S_CLEAR     = 11'b00000000001,
      S_IDLE      = 11'b00000000010,
      S_EXEC      = 11'b00000000100,
      S_LOAD_RD   = 11'b00000001000,
      S_LOAD_CAP  = 11'b00000010000,
      S_ALLOC_CHK = 11'b00000100000,
      S_ALLOC     = 11'b00001000000,
      S_STORE     = 11'b00010000000,
      S_COMMIT    = 11'b00100000000,
      S_COPY_OUT  = 11'b01000000000,
      S_DONE      = 11'b10000000000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [3:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [TAG_W-1:0]   atag_ff, atag_in;
   logic               step_ff, step_in;
   logic               src_ff, src_in;
   logic [7:0]         nest_ff, nest_in;
   logic [63:0]        saved_ff, saved_in;
   logic [63:0]        ld_ff, ld_in;
   logic [1:0]         status_ff, status_in;
   logic               redir_ff, redir_in;
   logic [63:0]        rtarget_ff, rtarget_in;
   logic [7:0]         reason_ff, reason_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [3:0]         size;
   logic [ADDR_W-1:0]  byte_addr;
   logic [ADDR_W-1:0]  last_addr;
   logic [TAG_W-1:0]   t0, t1, tag_a;
   logic               txn;
   logic [7:0]         store_byte;
   logic [7:0]         cap_byte;
   logic [CNT_W-1:0]   cnt_m1;
   logic               last_cnt;
   logic               last_slot;
   logic               last_byte;
   logic [1:0]         need;
   logic               full;
   logic [63:0]        ld_ext;

   dir_ctl_type        dir_ctl;
   logic               hit_a, hit_b, rd_valid;
   logic [SLOT_W-1:0]  slot_a, free_slot;
   logic [USED_W-1:0]  used;
   logic [TAG_W-1:0]   rd_tag;

   logic               clr_busy;
   logic               bm_we, lb_we;
   logic [ADDR_W-1:0]  bm_addr;
   logic [7:0]         bm_wdata, bm_rdata, lb_wdata, lb_rdata;
   logic [LB_AW-1:0]   lb_addr;

   tsb_line_dir #(
      .LINE_BYTES(LINE_BYTES), .BUFFER_LINES(BUFFER_LINES),
      .TAG_W(TAG_W), .SLOT_W(SLOT_W), .USED_W(USED_W)
   ) u_dir (
      .clock(clock), .reset(reset), .ctl(dir_ctl),
      .wr_slot(slot_ff), .wr_tag(atag_ff),
      .tag_a(tag_a), .hit_a(hit_a), .slot_a(slot_a),
      .tag_b(t1), .hit_b(hit_b), .free_slot(free_slot), .used(used),
      .rd_idx(slot_ff), .rd_valid(rd_valid), .rd_tag(rd_tag)
   );

   tsb_mem #(
      .LINE_BYTES(LINE_BYTES), .BUFFER_LINES(BUFFER_LINES), .LB_AW(LB_AW)
   ) u_mem (
      .clock(clock), .reset(reset), .clr_busy(clr_busy),
      .bm_we(bm_we), .bm_addr(bm_addr), .bm_wdata(bm_wdata), .bm_rdata(bm_rdata),
      .lb_we(lb_we), .lb_addr(lb_addr), .lb_wdata(lb_wdata), .lb_rdata(lb_rdata)
   );

   assign size       = 4'd1 << req_ff.size_code;
   assign byte_addr  = req_ff.addr + ADDR_W'(idx_ff);
   assign last_addr  = req_ff.addr + ADDR_W'(size - 4'd1);
   assign t0         = req_ff.addr[ADDR_W-1:OFF_W];
   assign t1         = last_addr[ADDR_W-1:OFF_W];
   assign txn        = nest_ff != 8'd0;
   assign store_byte = 8'(req_ff.store_data >> {idx_ff[2:0], 3'b000});
   assign cap_byte   = src_ff ? lb_rdata : bm_rdata;
   assign cnt_m1     = cnt_ff - 1'b1;
   assign last_cnt   = cnt_ff == CNT_W'(LINE_BYTES);
   assign last_slot  = slot_ff == SLOT_W'(BUFFER_LINES - 1);
   assign last_byte  = (idx_ff + 4'd1) == size;
   assign need       = {1'b0, !hit_a} + {1'b0, (t1 != t0) && !hit_b};
   assign full       = (used + USED_W'(need)) > USED_W'(BUFFER_LINES);

   always_comb begin
      if (state_ff == S_EXEC) begin
         tag_a = t0;
      end else if (state_ff == S_ALLOC_CHK) begin
         tag_a = step_ff ? t1 : t0;
      end else begin
         tag_a = byte_addr[ADDR_W-1:OFF_W];
      end
   end

   always_comb begin
      unique case (req_ff.size_code)
         2'd0: ld_ext = {{56{ld_ff[7]}}, ld_ff[7:0]};
         2'd1: ld_ext = {{48{ld_ff[15]}}, ld_ff[15:0]};
         2'd2: ld_ext = {{32{ld_ff[31]}}, ld_ff[31:0]};
         default: ld_ext = ld_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      atag_in      = atag_ff;
      step_in      = step_ff;
      src_in       = src_ff;
      nest_in      = nest_ff;
      saved_in     = saved_ff;
      ld_in        = ld_ff;
      status_in    = status_ff;
      redir_in     = redir_ff;
      rtarget_in   = rtarget_ff;
      reason_in    = reason_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      bm_we        = 1'b0;
      bm_addr      = byte_addr;
      bm_wdata     = store_byte;
      lb_we        = 1'b0;
      lb_addr      = {slot_a, byte_addr[OFF_W-1:0]};
      lb_wdata     = store_byte;
      dir_ctl      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            if (!clr_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            ld_in      = '0;
            status_in  = ST_OK;
            redir_in   = 1'b0;
            rtarget_in = '0;
            reason_in  = '0;
            idx_in     = '0;
            step_in    = 1'b0;
            state_in   = S_DONE;
            priority case (req_ff.cmd)
               CMD_LOAD: begin
                  state_in = S_LOAD_RD;
               end
               CMD_STORE: begin
                  if (!txn) begin
                     state_in = S_STORE;
                  end else if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     state_in = S_ALLOC_CHK;
                  end
               end
               CMD_BEGIN: begin
                  if (nest_ff == NEST_MAX) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     if (!txn) begin
                        saved_in      = req_ff.abort_target;
                        dir_ctl.clear = 1'b1;
                     end
                     nest_in = nest_ff + 8'd1;
                  end
               end
               CMD_END: begin
                  if (!txn) begin
                     status_in = ST_NO_TXN;
                  end else begin
                     nest_in = nest_ff - 8'd1;
                     if (nest_ff == 8'd1) begin
                        slot_in  = '0;
                        state_in = S_COMMIT;
                     end
                  end
               end
               CMD_ABORT: begin
                  if (txn) begin
                     nest_in       = '0;
                     dir_ctl.clear = 1'b1;
                     redir_in      = 1'b1;
                     rtarget_in    = saved_ff;
                     reason_in     = req_ff.abort_code;
                  end
               end
               default: begin
               end
            endcase
         end
         S_LOAD_RD: begin
            src_in   = txn && hit_a;
            state_in = S_LOAD_CAP;
         end
         S_LOAD_CAP: begin
            ld_in  = ld_ff | (64'(cap_byte) << {idx_ff[2:0], 3'b000});
            idx_in = idx_ff + 4'd1;
            if (last_byte) begin
               state_in = S_DONE;
            end else begin
               state_in = S_LOAD_RD;
            end
         end
         S_ALLOC_CHK: begin
            if (!hit_a) begin
               slot_in  = free_slot;
               atag_in  = tag_a;
               cnt_in   = '0;
               state_in = S_ALLOC;
            end else if (!step_ff) begin
               step_in = 1'b1;
            end else begin
               idx_in   = '0;
               state_in = S_STORE;
            end
         end
         S_ALLOC: begin
            bm_addr  = {atag_ff, cnt_ff[OFF_W-1:0]};
            lb_we    = cnt_ff != '0;
            lb_addr  = {slot_ff, cnt_m1[OFF_W-1:0]};
            lb_wdata = bm_rdata;
            if (last_cnt) begin
               dir_ctl.alloc = 1'b1;
               state_in      = S_ALLOC_CHK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_STORE: begin
            if (txn && hit_a) begin
               lb_we = 1'b1;
            end else begin
               bm_we = 1'b1;
            end
            idx_in = idx_ff + 4'd1;
            if (last_byte) begin
               state_in = S_DONE;
            end
         end
         S_COMMIT: begin
            if (rd_valid) begin
               atag_in  = rd_tag;
               cnt_in   = '0;
               state_in = S_COPY_OUT;
            end else if (last_slot) begin
               dir_ctl.clear = 1'b1;
               state_in      = S_DONE;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         S_COPY_OUT: begin
            lb_addr  = {slot_ff, cnt_ff[OFF_W-1:0]};
            bm_we    = cnt_ff != '0;
            bm_addr  = {atag_ff, cnt_m1[OFF_W-1:0]};
            bm_wdata = lb_rdata;
            if (!last_cnt) begin
               cnt_in = cnt_ff + 1'b1;
            end else if (last_slot) begin
               dir_ctl.clear = 1'b1;
               state_in      = S_DONE;
            end else begin
               slot_in  = slot_ff + 1'b1;
               state_in = S_COMMIT;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.load_data       = req_ff.sign_extend ? ld_ext : ld_ff;
               rsp_in.status          = status_ff;
               rsp_in.in_txn          = txn;
               rsp_in.redirect_valid  = redir_ff;
               rsp_in.redirect_target = rtarget_ff;
               rsp_in.abort_reason    = reason_ff;
               rsp_valid_in           = 1'b1;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         nest_ff      <= '0;
         saved_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nest_ff      <= nest_in;
         saved_ff     <= saved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      cnt_ff     <= cnt_in;
      slot_ff    <= slot_in;
      atag_ff    <= atag_in;
      step_ff    <= step_in;
      src_ff     <= src_in;
      ld_ff      <= ld_in;
      status_ff  <= status_in;
      redir_ff   <= redir_in;
      rtarget_ff <= rtarget_in;
      reason_ff  <= reason_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall   = state_ff != S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_EXEC)
      else $error("accepted request not executed");
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall) |=> rsp_valid_ff)
      else $error("finished request produced no response");
   a_alloc_txn: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ALLOC |-> txn)
      else $error("line fill outside a transaction");
   a_commit_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COPY_OUT |-> !txn)
      else $error("commit while a transaction is open");

endmodule

// ===== tb/transactional_store_buffer_unit_tb.sv =====
// Testbench for transactional_store_buffer_unit: directed table, nest overflow run,
// then random transactions checked against a behavioral predictor. Depends on tsb_pkg.
module transactional_store_buffer_unit_tb;
   import tsb_pkg::*;

   localparam int MEM_BYTES = 4096;
   localparam int LB = 64;
   localparam int NL = 16;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;

   transactional_store_buffer_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   // Predictor state.
   logic [7:0] mem_model [MEM_BYTES];
   logic [7:0] buf_bytes [NL*LB];
   logic [5:0] buf_tag [NL];
   logic buf_valid [NL];
   int buf_used;
   int nest;
   logic [63:0] saved_target;

   rsp_type pending_rsp [$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit quiet_tail = 1'b0;
   bit hold_off = 1'b0;

   function automatic int find_slot(logic [5:0] tg);
      for (int i = 0; i < NL; i++)
         if (buf_valid[i] && buf_tag[i] == tg) return i;
      return -1;
   endfunction

   function automatic void fill_slot(logic [5:0] tg);
      for (int i = 0; i < NL; i++)
         if (!buf_valid[i]) begin
            for (int k = 0; k < LB; k++) buf_bytes[i*LB+k] = mem_model[tg*LB+k];
            buf_tag[i] = tg;
            buf_valid[i] = 1'b1;
            buf_used++;
            return;
         end
   endfunction

   function automatic void drop_buffer();
      for (int i = 0; i < NL; i++) buf_valid[i] = 1'b0;
      buf_used = 0;
   endfunction

   function automatic logic [7:0] read_byte(logic [11:0] a, bit txn);
      int s;
      s = txn ? find_slot(a[11:6]) : -1;
      return (s >= 0) ? buf_bytes[s*LB + a[5:0]] : mem_model[a];
   endfunction

   function automatic void write_byte(logic [11:0] a, bit txn, logic [7:0] v);
      int s;
      s = txn ? find_slot(a[11:6]) : -1;
      if (s >= 0) buf_bytes[s*LB + a[5:0]] = v;
      else mem_model[a] = v;
   endfunction

   function automatic rsp_type predict_access(req_type r);
      rsp_type o;
      int sz;
      bit txn;
      logic [11:0] a;
      logic [5:0] t0, t1;
      int need;
      bit ok;
      o = '0;
      sz = 1 << r.size_code;
      txn = nest != 0;
      case (r.cmd)
         CMD_LOAD: begin
            for (int i = 0; i < sz; i++) begin
               a = r.addr + 12'(i);
               o.load_data[8*i +: 8] = read_byte(a, txn);
            end
            if (r.sign_extend && sz < 8 && o.load_data[8*sz-1])
               for (int b = 8*sz; b < 64; b++) o.load_data[b] = 1'b1;
         end
         CMD_STORE: begin
            ok = 1'b1;
            if (txn) begin
               t0 = r.addr[11:6];
               a = r.addr + 12'(sz - 1);
               t1 = a[11:6];
               need = (find_slot(t0) < 0) ? 1 : 0;
               if (t1 != t0 && find_slot(t1) < 0) need++;
               if (buf_used + need > NL) begin
                  ok = 1'b0;
                  o.status = ST_FULL;
               end else begin
                  if (find_slot(t0) < 0) fill_slot(t0);
                  if (find_slot(t1) < 0) fill_slot(t1);
               end
            end
            if (ok)
               for (int i = 0; i < sz; i++) begin
                  a = r.addr + 12'(i);
                  write_byte(a, txn, r.store_data[8*i +: 8]);
               end
         end
         CMD_BEGIN: begin
            if (nest >= 255) o.status = ST_OVERFLOW;
            else begin
               if (nest == 0) begin
                  saved_target = r.abort_target;
                  drop_buffer();
               end
               nest++;
            end
         end
         CMD_END: begin
            if (nest == 0) o.status = ST_NO_TXN;
            else begin
               nest--;
               if (nest == 0) begin
                  for (int i = 0; i < NL; i++)
                     if (buf_valid[i])
                        for (int k = 0; k < LB; k++)
                           mem_model[buf_tag[i]*LB+k] = buf_bytes[i*LB+k];
                  drop_buffer();
               end
            end
         end
         CMD_ABORT: begin
            if (nest != 0) begin
               nest = 0;
               drop_buffer();
               o.redirect_valid = 1'b1;
               o.redirect_target = saved_target;
               o.abort_reason = r.abort_code;
            end
         end
         default: ;
      endcase
      o.in_txn = nest != 0;
      return o;
   endfunction

   // Directed rows: request plus an optional typed-in expectation.
   typedef struct {
      req_type r;
      bit fixed;
      rsp_type e;
   } row_type;

   function automatic req_type mk(logic [2:0] c, logic [11:0] a, logic [1:0] s,
                                  logic x, logic [63:0] d, logic [63:0] t,
                                  logic [7:0] k);
      req_type r;
      r.cmd = c; r.addr = a; r.size_code = s; r.sign_extend = x;
      r.store_data = d; r.abort_target = t; r.abort_code = k;
      return r;
   endfunction

   function automatic rsp_type rs(logic [63:0] ld, logic [1:0] st, logic tx,
                                  logic rv, logic [63:0] rt, logic [7:0] ar);
      rsp_type o;
      o.load_data = ld; o.status = st; o.in_txn = tx; o.redirect_valid = rv;
      o.redirect_target = rt; o.abort_reason = ar;
      return o;
   endfunction

   row_type rows [$];

   task automatic send(req_type r, bit fixed, rsp_type e);
      rsp_type p;
      int gap;
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 18);
         repeat (gap) @(negedge clock);
      end
      req_payload <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_access(r);
      if (fixed && p != e)
         $display("%0t table row disagrees with predictor: exp %h got %h", $time, e, p);
      pending_rsp.push_back(fixed ? e : p);
      @(negedge clock);
   endtask

   function automatic req_type rand_req();
      req_type r;
      int pick;
      r.store_data = {$urandom, $urandom};
      r.abort_target = {$urandom, $urandom};
      r.abort_code = 8'($urandom);
      r.size_code = 2'($urandom);
      r.sign_extend = 1'($urandom);
      // Mostly cluster addresses so that loads hit stored lines.
      r.addr = ($urandom_range(0, 3) == 0) ? 12'($urandom)
               : {2'($urandom_range(0, 3)) , 4'($urandom_range(0, 5)), 6'($urandom)};
      if ($urandom_range(0, 15) == 0) r.addr = 12'hFFF - 12'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 35) r.cmd = CMD_LOAD;
      else if (pick < 75) r.cmd = CMD_STORE;
      else if (pick < 85) r.cmd = CMD_BEGIN;
      else if (pick < 94) r.cmd = CMD_END;
      else if (pick < 98) r.cmd = CMD_ABORT;
      else r.cmd = 3'($urandom_range(5, 7));
      return r;
   endfunction

   initial begin : stimulus
      rsp_type z;
      for (int i = 0; i < MEM_BYTES; i++) mem_model[i] = '0;
      drop_buffer();
      nest = 0;
      saved_target = '0;
      z = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      rows.push_back('{mk(CMD_LOAD, 12'h000, 2'd3, 1'b0, '0, '0, '0), 1, rs(0, ST_OK, 0, 0, 0, 0)});
      rows.push_back('{mk(CMD_END, 12'h000, 2'd0, 1'b0, '0, '0, '0), 1, rs(0, ST_NO_TXN, 0, 0, 0, 0)});
      rows.push_back('{mk(CMD_ABORT, 12'h000, 2'd0, 1'b0, '0, '0, 8'hFF), 1, rs(0, ST_OK, 0, 0, 0, 0)});
      rows.push_back('{mk(3'd7, 12'hFFF, 2'd3, 1'b1, '1, '1, '1), 1, rs(0, ST_OK, 0, 0, 0, 0)});
      rows.push_back('{mk(CMD_STORE, 12'hFFC, 2'd3, 1'b0, 64'h8877665544332211, '0, '0), 1, z});
      rows.push_back('{mk(CMD_LOAD, 12'h000, 2'd2, 1'b1, '0, '0, '0), 1,
                       rs(64'hFFFFFFFF88776655, ST_OK, 0, 0, 0, 0)});
      rows.push_back('{mk(CMD_LOAD, 12'hFFC, 2'd0, 1'b1, '0, '0, '0), 1,
                       rs(64'h11, ST_OK, 0, 0, 0, 0)});
      rows.push_back('{mk(CMD_BEGIN, 12'h000, 2'd0, 1'b0, '0, 64'hFFFFFFFFFFFFFFFF, '0), 1,
                       rs(0, ST_OK, 1, 0, 0, 0)});
      rows.push_back('{mk(CMD_STORE, 12'h03D, 2'd3, 1'b0, 64'hFEDCBA9876543210, '0, '0), 0, z});
      rows.push_back('{mk(CMD_LOAD, 12'h03D, 2'd3, 1'b0, '0, '0, '0), 0, z});
      rows.push_back('{mk(CMD_LOAD, 12'hFFE, 2'd1, 1'b1, '0, '0, '0), 0, z});
      rows.push_back('{mk(CMD_BEGIN, 12'h000, 2'd0, 1'b0, '0, 64'h1234, '0), 0, z});
      rows.push_back('{mk(CMD_END, 12'h000, 2'd0, 1'b0, '0, '0, '0), 0, z});
      rows.push_back('{mk(CMD_ABORT, 12'h000, 2'd0, 1'b0, '0, '0, 8'hA5), 1,
                       rs(0, ST_OK, 0, 1, 64'hFFFFFFFFFFFFFFFF, 8'hA5)});
      rows.push_back('{mk(CMD_LOAD, 12'h03D, 2'd3, 1'b0, '0, '0, '0), 0, z});
      rows.push_back('{mk(CMD_BEGIN, 12'h000, 2'd0, 1'b0, '0, 64'h0, '0), 0, z});
      for (int i = 0; i < 17; i++)
         rows.push_back('{mk(CMD_STORE, 12'(i*64 + 1), 2'd0, 1'b0, 64'(i+1), '0, '0), 0, z});
      rows.push_back('{mk(CMD_END, 12'h000, 2'd0, 1'b0, '0, '0, '0), 0, z});
      rows.push_back('{mk(CMD_LOAD, 12'h001, 2'd0, 1'b0, '0, '0, '0), 0, z});

      foreach (rows[i]) send(rows[i].r, rows[i].fixed, rows[i].e);

      // Nest overflow: 255 begins, one more, then unwind with an abort.
      for (int i = 0; i < 256; i++)
         send(mk(CMD_BEGIN, 12'h000, 2'd0, 1'b0, '0, 64'(i), '0), 0, z);
      send(mk(CMD_ABORT, 12'h000, 2'd0, 1'b0, '0, '0, 8'h00), 1,
           rs(0, ST_OK, 0, 1, 64'd0, 8'h00));

      for (int n = 0; n < 1600; n++) begin
         if (n == 300) hold_off <= 1'b1;
         if (n == 1400) quiet_tail = 1'b1;
         send(rand_req(), 0, z);
      end
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // Receiver stall: random bursts plus one long hold-off.
   initial begin : rsp_side
      int n;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
            rsp_stall <= 1'b0;
            @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            n = $urandom_range(1, 18);
            repeat (n) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
            n = $urandom_range(1, 18);
            repeat (n) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected response: got %h", $time, rsp_payload);
            mismatches++;
         end else if (rsp_payload !== pending_rsp[0]) begin
            $display("%0t mismatch: expected %h actual %h", $time, pending_rsp[0], rsp_payload);
            mismatches++;
            void'(pending_rsp.pop_front());
         end else begin
            void'(pending_rsp.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
